>>> rtl/pdm_pkg.sv
// package for the pwm duty meter with adaptive debounce
// widths, reset values, register indexes, divide-by-20 constants and result types
`default_nettype none

package pdm_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned DEB_W  = 16;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned CFG_W  = 16;

    localparam logic [DEB_W-1:0] RESET_INITIAL_DEBOUNCE = 16'd50;
    localparam logic [DEB_W-1:0] RESET_MIN_DEBOUNCE     = 16'd2;
    localparam logic [DEB_W-1:0] RESET_MAX_DEBOUNCE     = 16'd5000;

    // period / 20 with a 16-bit quotient: periods at or above this saturate
    localparam logic [TIME_W-1:0] PERIOD_SAT   = 32'd1310720;
    // (period >> 2) / 5 == ((period >> 2) * RECIP_FIVE) >> RECIP_SHIFT below PERIOD_SAT
    localparam int unsigned       QUOT_IN_W    = 19;
    localparam logic [18:0]       RECIP_FIVE   = 19'd419431;
    localparam int unsigned       RECIP_SHIFT  = 21;

    typedef enum logic [1:0] {
        CFG_INITIAL_DEBOUNCE = 2'd0,
        CFG_MIN_DEBOUNCE     = 2'd1,
        CFG_MAX_DEBOUNCE     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [TIME_W-1:0] high_time;
        logic [TIME_W-1:0] low_time;
        logic              measurement_ready;
        logic              edge_accepted;
        logic              edge_dropped;
        logic [CNT_W-1:0]  accepted_edges;
        logic [CNT_W-1:0]  dropped_edges;
        logic [DEB_W-1:0]  current_debounce;
        logic [TIME_W-1:0] last_update_time;
        logic [CNT_W-1:0]  sample_count;
    } result_t;

    typedef struct packed {
        result_t res;
        logic    deb_pending;
    } stage_t;

endpackage

`default_nettype wire

>>> rtl/pdm_if.sv
// request channels of the pwm duty meter: pin samples in, measurement results out
// depends on pdm_pkg
`default_nettype none

interface pdm_sample_if;
    logic                          valid;
    logic                          ready;
    logic                          pin_level;
    logic [pdm_pkg::TIME_W-1:0]    time_us;

    modport source (output valid, output pin_level, output time_us, input ready);
    modport sink   (input valid, input pin_level, input time_us, output ready);
endinterface

interface pdm_result_if;
    logic                          valid;
    logic                          ready;
    logic [pdm_pkg::TIME_W-1:0]    high_time;
    logic [pdm_pkg::TIME_W-1:0]    low_time;
    logic                          measurement_ready;
    logic                          edge_accepted;
    logic                          edge_dropped;
    logic [pdm_pkg::CNT_W-1:0]     accepted_edges;
    logic [pdm_pkg::CNT_W-1:0]     dropped_edges;
    logic [pdm_pkg::DEB_W-1:0]     current_debounce;
    logic [pdm_pkg::TIME_W-1:0]    last_update_time;
    logic [pdm_pkg::CNT_W-1:0]     sample_count;

    modport source (output valid, output high_time, output low_time,
                    output measurement_ready, output edge_accepted, output edge_dropped,
                    output accepted_edges, output dropped_edges, output current_debounce,
                    output last_update_time, output sample_count, input ready);
    modport sink   (input valid, input high_time, input low_time,
                    input measurement_ready, input edge_accepted, input edge_dropped,
                    input accepted_edges, input dropped_edges, input current_debounce,
                    input last_update_time, input sample_count, output ready);
endinterface

`default_nettype wire

>>> rtl/pdm_deb_calc.sv
// adaptive debounce value: clamp(period / 20) to min, then to max
// divide by 20 as shift plus reciprocal multiply; depends on pdm_pkg
`default_nettype none

module pdm_deb_calc
(
    input  wire logic [pdm_pkg::TIME_W-1:0] period,
    input  wire logic [pdm_pkg::DEB_W-1:0]  min_deb,
    input  wire logic [pdm_pkg::DEB_W-1:0]  max_deb,
    output logic      [pdm_pkg::DEB_W-1:0]  debounce
);

    localparam int unsigned PROD_W = 2 * pdm_pkg::QUOT_IN_W;

    logic                              saturate;
    logic [pdm_pkg::QUOT_IN_W-1:0]     quarter;
    logic [PROD_W-1:0]                 product;
    logic [pdm_pkg::DEB_W-1:0]         quotient;
    logic [pdm_pkg::DEB_W-1:0]         raised;

    always_comb
    begin
        saturate = (period >= pdm_pkg::PERIOD_SAT);
        quarter  = period[pdm_pkg::QUOT_IN_W+1:2];
        product  = {{pdm_pkg::QUOT_IN_W{1'b0}}, quarter}
                 * {{pdm_pkg::QUOT_IN_W{1'b0}}, pdm_pkg::RECIP_FIVE};
        quotient = product[pdm_pkg::RECIP_SHIFT +: pdm_pkg::DEB_W];
        raised   = (quotient < min_deb) ? min_deb : quotient;
        if (saturate)
        begin
            debounce = max_deb;
        end
        else
        begin
            debounce = (raised > max_deb) ? max_deb : raised;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pwm_duty_meter_adaptive_debounce.sv
// pwm duty meter with adaptive debounce, top level
// depends on pdm_pkg, pdm_if (pdm_sample_if, pdm_result_if) and pdm_deb_calc
//
// sample channel: one request per pin sample (pin_level, time_us). every
// sample yields one result request; the first sample after reset only primes
// the last level and time and reports the current state. results carry the
// high/low times, flags, counters and the debounce value in force after that
// sample.
// a sample accepted goes through two register stages (s1, s2) to the result
// channel. throughput: one sample per cycle while the receiver takes results.
// a debounce update from an accepted edge is held as a pending period and
// resolved through one reciprocal multiply in the following cycle; the edge
// compare of the next sample uses that resolved value.
// when the receiver stalls, the two stages fill and then sample ready drops;
// nothing is lost or repeated.
// configuration: cfg_we/cfg_index/cfg_data write initial, min and max
// debounce; writing initial debounce before the first accepted edge also
// loads the debounce in force. write only while the block is idle.
// reset: all state but the stage data clears, min and max return to 2/5000
// and the debounce in force returns to 50; no clearing pass is needed.
`default_nettype none

module pwm_duty_meter_adaptive_debounce
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [pdm_pkg::CFG_W-1:0] cfg_data,
    pdm_sample_if.sink                     sample,
    pdm_result_if.source                   result
);

    logic [pdm_pkg::DEB_W-1:0]  min_deb_reg;
    logic [pdm_pkg::DEB_W-1:0]  max_deb_reg;

    logic                       primed_reg;
    logic                       prev_level_reg;
    logic [pdm_pkg::TIME_W-1:0] prev_time_reg;
    logic [pdm_pkg::TIME_W-1:0] high_reg;
    logic [pdm_pkg::TIME_W-1:0] low_reg;
    logic [pdm_pkg::DEB_W-1:0]  deb_reg;
    logic                       ready_flag_reg;
    logic [pdm_pkg::CNT_W-1:0]  edge_cnt_reg;
    logic [pdm_pkg::CNT_W-1:0]  drop_cnt_reg;
    logic [pdm_pkg::TIME_W-1:0] stamp_reg;
    logic [pdm_pkg::CNT_W-1:0]  sample_cnt_reg;
    logic                       pend_reg;
    logic [pdm_pkg::TIME_W-1:0] period_reg;

    logic                       primed_next;
    logic                       prev_level_next;
    logic [pdm_pkg::TIME_W-1:0] prev_time_next;
    logic [pdm_pkg::TIME_W-1:0] high_next;
    logic [pdm_pkg::TIME_W-1:0] low_next;
    logic                       ready_flag_next;
    logic [pdm_pkg::CNT_W-1:0]  edge_cnt_next;
    logic [pdm_pkg::CNT_W-1:0]  drop_cnt_next;
    logic [pdm_pkg::TIME_W-1:0] stamp_next;
    logic [pdm_pkg::CNT_W-1:0]  sample_cnt_next;
    logic [pdm_pkg::TIME_W-1:0] period_next;
    logic                       update_next;

    logic                       s1_valid_reg;
    pdm_pkg::stage_t            s1_reg;
    logic                       s2_valid_reg;
    pdm_pkg::result_t           s2_reg;
    pdm_pkg::result_t           s1_out;

    logic                       accept;
    logic                       s1_move;
    logic [pdm_pkg::DEB_W-1:0]  calc_deb;
    logic [pdm_pkg::DEB_W-1:0]  eff_deb;
    logic [pdm_pkg::TIME_W-1:0] diff;
    logic                       changed;
    logic                       acc;
    logic                       drop;
    pdm_pkg::result_t           res_next;

    pdm_deb_calc u_deb_calc
    (
        .period   (period_reg),
        .min_deb  (min_deb_reg),
        .max_deb  (max_deb_reg),
        .debounce (calc_deb)
    );

    // debounce in force for the sample at the input this cycle
    assign eff_deb = pend_reg ? calc_deb : deb_reg;

    assign s1_move      = s1_valid_reg && (!s2_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_move;
    assign accept       = sample.valid && sample.ready;

    always_comb
    begin
        diff            = sample.time_us - prev_time_reg;
        changed         = primed_reg && (sample.pin_level != prev_level_reg);
        acc             = changed && (diff >= {{(pdm_pkg::TIME_W-pdm_pkg::DEB_W){1'b0}}, eff_deb});
        drop            = changed && !acc;

        primed_next     = 1'b1;
        prev_level_next = prev_level_reg;
        prev_time_next  = prev_time_reg;
        high_next       = high_reg;
        low_next        = low_reg;
        ready_flag_next = ready_flag_reg;
        edge_cnt_next   = edge_cnt_reg;
        drop_cnt_next   = drop_cnt_reg;
        stamp_next      = stamp_reg;
        sample_cnt_next = sample_cnt_reg;

        if (!primed_reg)
        begin
            prev_level_next = sample.pin_level;
            prev_time_next  = sample.time_us;
        end
        else
        begin
            sample_cnt_next = sample_cnt_reg + 1'b1;
            if (changed)
            begin
                prev_level_next = sample.pin_level;
                prev_time_next  = sample.time_us;
            end
        end

        if (acc)
        begin
            if (sample.pin_level)
            begin
                low_next = diff;
            end
            else
            begin
                high_next = diff;
            end
            stamp_next      = sample.time_us;
            ready_flag_next = 1'b1;
            edge_cnt_next   = edge_cnt_reg + 1'b1;
        end

        if (drop)
        begin
            drop_cnt_next = drop_cnt_reg + 1'b1;
        end

        period_next = high_next + low_next;
        update_next = acc && (period_next != '0);

        res_next.high_time         = high_next;
        res_next.low_time          = low_next;
        res_next.measurement_ready = ready_flag_next;
        res_next.edge_accepted     = acc;
        res_next.edge_dropped      = drop;
        res_next.accepted_edges    = edge_cnt_next;
        res_next.dropped_edges     = drop_cnt_next;
        res_next.current_debounce  = eff_deb;
        res_next.last_update_time  = stamp_next;
        res_next.sample_count      = sample_cnt_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_deb_reg  <= pdm_pkg::RESET_MIN_DEBOUNCE;
            max_deb_reg  <= pdm_pkg::RESET_MAX_DEBOUNCE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                // only loads the debounce in force, and only before the first accepted edge
                pdm_pkg::CFG_INITIAL_DEBOUNCE: ;
                pdm_pkg::CFG_MIN_DEBOUNCE:     min_deb_reg  <= cfg_data;
                pdm_pkg::CFG_MAX_DEBOUNCE:     max_deb_reg  <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg     <= 1'b0;
            prev_level_reg <= 1'b0;
            prev_time_reg  <= '0;
            high_reg       <= '0;
            low_reg        <= '0;
            ready_flag_reg <= 1'b0;
            edge_cnt_reg   <= '0;
            drop_cnt_reg   <= '0;
            stamp_reg      <= '0;
            sample_cnt_reg <= '0;
            pend_reg       <= 1'b0;
            period_reg     <= '0;
            deb_reg        <= pdm_pkg::RESET_INITIAL_DEBOUNCE;
        end
        else
        begin
            pend_reg <= accept && update_next;
            if (accept)
            begin
                primed_reg     <= primed_next;
                prev_level_reg <= prev_level_next;
                prev_time_reg  <= prev_time_next;
                high_reg       <= high_next;
                low_reg        <= low_next;
                ready_flag_reg <= ready_flag_next;
                edge_cnt_reg   <= edge_cnt_next;
                drop_cnt_reg   <= drop_cnt_next;
                stamp_reg      <= stamp_next;
                sample_cnt_reg <= sample_cnt_next;
                period_reg     <= period_next;
            end
            if (cfg_we && (cfg_index == pdm_pkg::CFG_INITIAL_DEBOUNCE) && !ready_flag_reg)
            begin
                deb_reg <= cfg_data;
            end
            else
            begin
                deb_reg <= eff_deb;
            end
        end
    end

    // stage one result with a pending debounce resolved
    always_comb
    begin
        s1_out = s1_reg.res;
        if (s1_reg.deb_pending)
        begin
            s1_out.current_debounce = calc_deb;
        end
    end

    // result stages; a pending debounce in stage one resolves in the cycle after load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.res         <= res_next;
            s1_reg.deb_pending <= update_next;
        end
        else if (s1_valid_reg && s1_reg.deb_pending)
        begin
            s1_reg.res.current_debounce <= calc_deb;
            s1_reg.deb_pending          <= 1'b0;
        end

        if (s1_move)
        begin
            s2_reg <= s1_out;
        end
    end

    assign result.valid             = s2_valid_reg;
    assign result.high_time         = s2_reg.high_time;
    assign result.low_time          = s2_reg.low_time;
    assign result.measurement_ready = s2_reg.measurement_ready;
    assign result.edge_accepted     = s2_reg.edge_accepted;
    assign result.edge_dropped      = s2_reg.edge_dropped;
    assign result.accepted_edges    = s2_reg.accepted_edges;
    assign result.dropped_edges     = s2_reg.dropped_edges;
    assign result.current_debounce  = s2_reg.current_debounce;
    assign result.last_update_time  = s2_reg.last_update_time;
    assign result.sample_count      = s2_reg.sample_count;

    a_pending_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.deb_pending) |-> pend_reg)
        else $error("stage one holds a pending debounce the state does not");

    a_pending_after_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ready_flag_reg)
        else $error("debounce update pending without an accepted edge");

    a_pending_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !accept) |=> !pend_reg)
        else $error("debounce update stayed pending");

    a_sample_yields: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted sample produced no result");

endmodule

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for pwm_duty_meter_adaptive_debounce
// depends on pdm_pkg, pdm_if and the rtl top level; predicts every result request
// from a local model of the edge meter and compares it field by field
`default_nettype none

module testbench;

    localparam logic [1:0]  CFG_UNUSED_INDEX = 2'd3;
    localparam int unsigned PERIOD_DIVISOR   = 20;
    localparam int unsigned PHASE_ITEMS      = 180;
    localparam int unsigned LONG_HOLD        = 400;

    typedef struct packed {
        logic                       pin_level;
        logic [pdm_pkg::TIME_W-1:0] time_us;
    } pin_sample_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [1:0]                 cfg_index;
    logic [pdm_pkg::CFG_W-1:0]  cfg_data;

    pdm_sample_if sample_ch ();
    pdm_result_if result_ch ();

    pwm_duty_meter_adaptive_debounce i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // meter model state and registers
    logic                       det_primed;
    logic                       det_level;
    logic [pdm_pkg::TIME_W-1:0] det_edge_time;
    logic [pdm_pkg::TIME_W-1:0] det_high;
    logic [pdm_pkg::TIME_W-1:0] det_low;
    logic [pdm_pkg::DEB_W-1:0]  det_debounce;
    logic                       det_ready;
    logic [pdm_pkg::CNT_W-1:0]  det_accepts;
    logic [pdm_pkg::CNT_W-1:0]  det_drops;
    logic [pdm_pkg::TIME_W-1:0] det_stamp;
    logic [pdm_pkg::CNT_W-1:0]  det_samples;
    logic [pdm_pkg::DEB_W-1:0]  reg_initial;
    logic [pdm_pkg::DEB_W-1:0]  reg_min;
    logic [pdm_pkg::DEB_W-1:0]  reg_max;

    pin_sample_t                pending_samples[$];
    pdm_pkg::result_t           expected_results[$];
    pin_sample_t                next_sample;
    pdm_pkg::result_t           got;
    pdm_pkg::result_t           want;
    logic                       sample_taken;
    int unsigned                mismatch_count;
    int unsigned                burst_left;
    int unsigned                gap_left;
    int unsigned                sender_style;
    int unsigned                stall_style;
    int unsigned                rx_tick;
    int unsigned                hold_left;
    logic                       hold_armed;
    logic                       stim_level;
    logic [pdm_pkg::TIME_W-1:0] stim_time;

    function automatic pdm_pkg::result_t meter_predict(input logic lvl,
                                                       input logic [pdm_pkg::TIME_W-1:0] now);
        logic [pdm_pkg::TIME_W-1:0] elapsed;
        logic [pdm_pkg::TIME_W-1:0] period;
        logic [pdm_pkg::TIME_W-1:0] quot;
        pdm_pkg::result_t           r;
        r = '0;
        if (!det_primed)
        begin
            det_primed    = 1'b1;
            det_level     = lvl;
            det_edge_time = now;
        end
        else
        begin
            det_samples = det_samples + 1'b1;
            if (lvl != det_level)
            begin
                elapsed = now - det_edge_time;
                if (elapsed >= {16'd0, det_debounce})
                begin
                    if (lvl)
                        det_low = elapsed;
                    else
                        det_high = elapsed;
                    det_stamp   = now;
                    det_ready   = 1'b1;
                    det_accepts = det_accepts + 1'b1;
                    period      = det_high + det_low;
                    if (period != '0)
                    begin
                        quot = period / PERIOD_DIVISOR;
                        if (quot < {16'd0, reg_min})
                            quot = {16'd0, reg_min};
                        if (quot > {16'd0, reg_max})
                            quot = {16'd0, reg_max};
                        det_debounce = quot[pdm_pkg::DEB_W-1:0];
                    end
                    r.edge_accepted = 1'b1;
                end
                else
                begin
                    det_drops      = det_drops + 1'b1;
                    r.edge_dropped = 1'b1;
                end
                det_edge_time = now;
                det_level     = lvl;
            end
        end
        r.high_time         = det_high;
        r.low_time          = det_low;
        r.measurement_ready = det_ready;
        r.accepted_edges    = det_accepts;
        r.dropped_edges     = det_drops;
        r.current_debounce  = det_debounce;
        r.last_update_time  = det_stamp;
        r.sample_count      = det_samples;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t %s: expected %h actual %h", $time, fname, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // acceptance of requests on both channels
    always @(posedge clk)
    begin
        sample_taken = sample_ch.valid && sample_ch.ready;
        if (sample_taken)
            expected_results.push_back(meter_predict(sample_ch.pin_level, sample_ch.time_us));
        if (result_ch.valid && result_ch.ready)
        begin
            got.high_time         = result_ch.high_time;
            got.low_time          = result_ch.low_time;
            got.measurement_ready = result_ch.measurement_ready;
            got.edge_accepted     = result_ch.edge_accepted;
            got.edge_dropped      = result_ch.edge_dropped;
            got.accepted_edges    = result_ch.accepted_edges;
            got.dropped_edges     = result_ch.dropped_edges;
            got.current_debounce  = result_ch.current_debounce;
            got.last_update_time  = result_ch.last_update_time;
            got.sample_count      = result_ch.sample_count;
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result request: expected none actual %h", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("high_time", want.high_time, got.high_time);
                check_field("low_time", want.low_time, got.low_time);
                check_field("measurement_ready", 32'(want.measurement_ready),
                            32'(got.measurement_ready));
                check_field("edge_accepted", 32'(want.edge_accepted),
                            32'(got.edge_accepted));
                check_field("edge_dropped", 32'(want.edge_dropped), 32'(got.edge_dropped));
                check_field("accepted_edges", want.accepted_edges, got.accepted_edges);
                check_field("dropped_edges", want.dropped_edges, got.dropped_edges);
                check_field("current_debounce", 32'(want.current_debounce),
                            32'(got.current_debounce));
                check_field("last_update_time", want.last_update_time,
                            got.last_update_time);
                check_field("sample_count", want.sample_count, got.sample_count);
            end
        end
    end

    // sample driver, bursts with gaps unless sender_style is 0
    always @(negedge clk)
    begin
        if (rst_n && (!sample_ch.valid || sample_taken))
        begin
            if (gap_left > 0)
            begin
                sample_ch.valid <= 1'b0;
                gap_left--;
            end
            else if (pending_samples.size() > 0)
            begin
                next_sample = pending_samples.pop_front();
                sample_ch.valid     <= 1'b1;
                sample_ch.pin_level <= next_sample.pin_level;
                sample_ch.time_us   <= next_sample.time_us;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = (sender_style == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // result receiver with its own stall pattern
    always @(negedge clk)
    begin
        rx_tick++;
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_armed)
        begin
            hold_armed = 1'b0;
            hold_left  = LONG_HOLD;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            case (stall_style)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 99) >= 30);
                default: result_ch.ready <= ((rx_tick % 7) < 4);
            endcase
        end
    end

    task automatic program_reg(input logic [1:0] idx, input logic [pdm_pkg::DEB_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            pdm_pkg::CFG_INITIAL_DEBOUNCE:
            begin
                reg_initial = value;
                if (!det_ready)
                    det_debounce = value;
            end
            pdm_pkg::CFG_MIN_DEBOUNCE: reg_min = value;
            pdm_pkg::CFG_MAX_DEBOUNCE: reg_max = value;
            default:                   ;
        endcase
    endtask

    task automatic push_step(input logic lvl, input logic [pdm_pkg::TIME_W-1:0] delta);
        stim_level = lvl;
        stim_time  = stim_time + delta;
        pending_samples.push_back({stim_level, stim_time});
    endtask

    task automatic push_random(input int unsigned count);
        int unsigned pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                push_step(!stim_level, $urandom_range(20, 2500));
            else if (pick < 65)
                push_step(!stim_level, ($urandom_range(0, 9) == 0) ? $urandom
                                                                    : $urandom_range(2500, 200000));
            else if (pick < 78)
                push_step(stim_level, $urandom_range(0, 300));
            else if (pick < 92)
                push_step(!stim_level, $urandom_range(0, 8));
            else
            begin
                stim_time = $urandom;
                push_step(1'($urandom_range(0, 1)), 0);
            end
        end
    endtask

    task automatic settle();
        while (pending_samples.size() != 0 || sample_ch.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("pwm_duty_meter_adaptive_debounce: mismatch");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = pdm_pkg::CFG_INITIAL_DEBOUNCE;
        cfg_data            = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.pin_level = 1'b0;
        sample_ch.time_us   = '0;
        result_ch.ready     = 1'b0;
        sample_taken        = 1'b0;
        mismatch_count      = 0;
        burst_left          = 0;
        gap_left            = 0;
        sender_style        = 1;
        stall_style         = 1;
        rx_tick             = 0;
        hold_left           = 0;
        hold_armed          = 1'b0;
        det_primed          = 1'b0;
        det_level           = 1'b0;
        det_edge_time       = '0;
        det_high            = '0;
        det_low             = '0;
        reg_initial         = pdm_pkg::RESET_INITIAL_DEBOUNCE;
        reg_min             = pdm_pkg::RESET_MIN_DEBOUNCE;
        reg_max             = pdm_pkg::RESET_MAX_DEBOUNCE;
        det_debounce        = pdm_pkg::RESET_INITIAL_DEBOUNCE;
        det_ready           = 1'b0;
        det_accepts         = '0;
        det_drops           = '0;
        det_stamp           = '0;
        det_samples         = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // initial debounce loaded before any accepted edge
        program_reg(pdm_pkg::CFG_INITIAL_DEBOUNCE, 16'hFFFF);
        stim_time = 32'hFFFF_FFF0;
        push_step(1'b1, 0);
        push_step(1'b1, 32'h10);
        push_step(1'b0, 32'h64);
        settle();
        program_reg(pdm_pkg::CFG_INITIAL_DEBOUNCE, 16'd50);
        push_step(1'b1, 49);
        push_step(1'b0, 50);
        push_step(1'b1, 1);
        push_step(1'b0, 2);
        push_step(1'b1, 2);
        // high plus low wraps to zero, then to the upper clamp
        push_step(1'b0, 32'hFFFF_FFFE);
        push_step(1'b1, 32'hFFFF_FFFF);
        push_step(1'b1, 32'h0000_1234);
        push_step(1'b0, 5000);
        settle();
        // min above max, late initial write and an unknown index
        program_reg(pdm_pkg::CFG_MIN_DEBOUNCE, 16'd60000);
        program_reg(pdm_pkg::CFG_MAX_DEBOUNCE, 16'd100);
        program_reg(pdm_pkg::CFG_INITIAL_DEBOUNCE, 16'd7);
        program_reg(CFG_UNUSED_INDEX, 16'hFFFF);
        push_step(1'b1, 300);
        push_step(1'b0, 99);
        push_step(1'b1, 100);
        push_step(1'b0, 0);
        settle();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    program_reg(pdm_pkg::CFG_INITIAL_DEBOUNCE, 16'd0);
                    program_reg(pdm_pkg::CFG_MIN_DEBOUNCE, 16'd0);
                    program_reg(pdm_pkg::CFG_MAX_DEBOUNCE, 16'hFFFF);
                    sender_style = 1;
                    stall_style  = 1;
                end
                1:
                begin
                    program_reg(pdm_pkg::CFG_MIN_DEBOUNCE, 16'($urandom_range(0, 40)));
                    program_reg(pdm_pkg::CFG_MAX_DEBOUNCE, 16'($urandom_range(200, 5000)));
                    sender_style = 0;
                    stall_style  = 0;
                end
                2:
                begin
                    program_reg(pdm_pkg::CFG_MIN_DEBOUNCE, 16'hFFFF);
                    program_reg(pdm_pkg::CFG_MAX_DEBOUNCE, 16'hFFFF);
                    sender_style = 1;
                    stall_style  = 2;
                end
                3:
                begin
                    program_reg(pdm_pkg::CFG_MIN_DEBOUNCE, 16'd0);
                    program_reg(pdm_pkg::CFG_MAX_DEBOUNCE, 16'd0);
                    sender_style = 0;
                    stall_style  = 1;
                end
                4:
                begin
                    program_reg(pdm_pkg::CFG_MIN_DEBOUNCE, 16'($urandom_range(0, 65535)));
                    program_reg(pdm_pkg::CFG_MAX_DEBOUNCE, 16'($urandom_range(0, 65535)));
                    sender_style = 1;
                    stall_style  = 2;
                end
                default:
                begin
                    program_reg(pdm_pkg::CFG_MIN_DEBOUNCE, 16'd30);
                    program_reg(pdm_pkg::CFG_MAX_DEBOUNCE, 16'd10);
                    sender_style = 1;
                    stall_style  = 0;
                end
            endcase
            push_random(PHASE_ITEMS);
            // receiver holds off while the sender keeps offering
            if (phase == 1)
                hold_armed = 1'b1;
            settle();
        end

        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("pwm_duty_meter_adaptive_debounce: match");
        else
            $display("pwm_duty_meter_adaptive_debounce: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/pdm_pkg.sv
rtl/pdm_if.sv
rtl/pdm_deb_calc.sv
rtl/pwm_duty_meter_adaptive_debounce.sv
verif/testbench.sv
